// ===== src/rsame_pkg.sv =====
// ----------------------------------------------------------------------------
// rsame_pkg: shared types and constants for the modular exponentiation block
// Holds the word width, register indexes and the operand type that walks
// along the multiplier cell chain.
// ----------------------------------------------------------------------------
package rsame_pkg;

   // width of every data word on the ports
   localparam int DATA_W = 16;

   // configuration register indexes
   localparam logic [1:0] CSR_PUBLIC_EXP  = 2'd0;
   localparam logic [1:0] CSR_PRIVATE_EXP = 2'd1;
   localparam logic [1:0] CSR_MODULUS     = 2'd2;

   // which working register a product returns to
   localparam logic TAG_BASE = 1'b0;
   localparam logic TAG_ACC  = 1'b1;

   // one modular product in flight: partial remainder, multiplier bits
   // (left aligned, consumed from the top) and multiplicand
   typedef struct packed {
      logic              valid;
      logic              tag;
      logic [DATA_W-1:0] r;
      logic [DATA_W-1:0] a;
      logic [DATA_W-1:0] b;
   } op_type;

endpackage

// ===== src/rsa_modular_exponentiation_top.sv =====
// ----------------------------------------------------------------------------
// rsa_modular_exponentiation_top: right-to-left square-and-multiply
// Raises each request word to the public or private exponent modulo the
// configured modulus, with the modular products formed in a cell chain.
// ----------------------------------------------------------------------------
// One word is worked on at a time. With W = min(KEY_BITS,16), a word first
// makes one pass through the W-cell multiplier chain to reduce the message,
// then one pass per exponent bit up to the top set bit of the selected
// exponent, where the multiply, when the bit is set, enters the chain in the
// cycle after the square and the sequencer waits for both to come back. A
// modulus of one or zero skips the chain. The request side is free again in
// the cycle after the response word is loaded, and a new word is taken while
// the previous result still waits on the response side; the finished word
// then holds until the response register is free. Exponent zero gives 1 mod
// n; a modulus of one or zero gives 0. Register writes are taken at any time,
// csr_ready is always high, and an index of three is ignored.
module rsa_modular_exponentiation_top #(
   parameter int KEY_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_action,
   input  logic [15:0] req_message,
   input  logic        req_last_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_result,
   output logic        rsp_last_out,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam int DW    = rsame_pkg::DATA_W;
   localparam int W     = (KEY_BITS < DW) ? KEY_BITS : DW;
   localparam int ALIGN = DW - W;
   localparam logic [DW-1:0] KMASK = DW'((64'd1 << W) - 64'd1);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_LOAD = 3'd1;
   localparam logic [2:0] S_SQ   = 3'd2;
   localparam logic [2:0] S_MUL  = 3'd3;
   localparam logic [2:0] S_WAIT = 3'd4;
   localparam logic [2:0] S_DONE = 3'd5;

   logic [DW-1:0] pub_ff, pub_in, priv_ff, priv_in, mod_ff, mod_in;
   logic [2:0]    state_ff, state_in;
   logic [DW-1:0] base_ff, base_in, acc_ff, acc_in, exp_ff, exp_in;
   logic          last_ff, last_in;
   logic          bit_ff, bit_in;
   logic [1:0]    cnt_ff, cnt_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [DW-1:0] rsp_result_ff, rsp_result_in;
   logic          rsp_last_ff, rsp_last_in;
   rsame_pkg::op_type issue, ret;
   logic          req_fire, out_free;

   // configuration registers
   always_comb begin
      pub_in  = pub_ff;
      priv_in = priv_ff;
      mod_in  = mod_ff;
      if (csr_valid) begin
         case (csr_index)
            rsame_pkg::CSR_PUBLIC_EXP:  pub_in  = csr_data & KMASK;
            rsame_pkg::CSR_PRIVATE_EXP: priv_in = csr_data & KMASK;
            rsame_pkg::CSR_MODULUS:     mod_in  = csr_data & KMASK;
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != S_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // multiplier chain
   rsame_chain #(.CELLS(W)) u_chain (
      .clock   (clock),
      .reset   (reset),
      .modulus (mod_ff),
      .op_in   (issue),
      .op_out  (ret)
   );

   // sequencer
   always_comb begin
      state_in      = state_ff;
      base_in       = base_ff;
      acc_in        = acc_ff;
      exp_in        = exp_ff;
      last_in       = last_ff;
      bit_in        = bit_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_result_in = rsp_result_ff;
      rsp_last_in   = rsp_last_ff;
      issue.valid   = 1'b0;
      issue.tag     = rsame_pkg::TAG_BASE;
      issue.r       = '0;
      issue.a       = '0;
      issue.b       = '0;

      if (ret.valid) begin
         if (ret.tag == rsame_pkg::TAG_ACC) begin
            acc_in = ret.r;
         end else begin
            base_in = ret.r;
         end
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               base_in  = req_message & KMASK;
               exp_in   = req_action ? priv_ff : pub_ff;
               last_in  = req_last_in;
               acc_in   = DW'(1);
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            if (mod_ff <= DW'(1)) begin
               acc_in   = '0;
               state_in = S_DONE;
            end else begin
               // message times one reduces it below the modulus
               issue.valid = 1'b1;
               issue.tag   = rsame_pkg::TAG_BASE;
               issue.a     = base_ff << ALIGN;
               issue.b     = DW'(1);
               state_in    = S_WAIT;
            end
         end
         S_SQ: begin
            issue.valid = 1'b1;
            issue.tag   = rsame_pkg::TAG_BASE;
            issue.a     = base_ff << ALIGN;
            issue.b     = base_ff;
            bit_in      = exp_ff[0];
            exp_in      = exp_ff >> 1;
            state_in    = S_MUL;
         end
         S_MUL: begin
            // base still holds its old value here
            if (bit_ff) begin
               issue.valid = 1'b1;
               issue.tag   = rsame_pkg::TAG_ACC;
               issue.a     = acc_ff << ALIGN;
               issue.b     = base_ff;
            end
            state_in = S_WAIT;
         end
         S_WAIT: begin
            if (cnt_ff == 2'd0) begin
               state_in = (exp_ff == '0) ? S_DONE : S_SQ;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_result_in = acc_ff;
               rsp_last_in   = last_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // products in flight
      cnt_in = cnt_ff + {1'b0, issue.valid} - {1'b0, ret.valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pub_ff       <= DW'(1);
         priv_ff      <= DW'(1);
         mod_ff       <= DW'(1);
         state_ff     <= S_IDLE;
         cnt_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pub_ff       <= pub_in;
         priv_ff      <= priv_in;
         mod_ff       <= mod_in;
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      base_ff       <= base_in;
      acc_ff        <= acc_in;
      exp_ff        <= exp_in;
      last_ff       <= last_in;
      bit_ff        <= bit_in;
      rsp_result_ff <= rsp_result_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_result   = rsp_result_ff;
   assign rsp_last_out = rsp_last_ff;

   // checks
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3) else $error("too many products in flight");
   a_ret_wait: assert property (@(posedge clock) disable iff (reset)
      ret.valid |-> (state_ff == S_WAIT)) else $error("product returned outside wait");
   a_done_mod: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && mod_ff > DW'(1)) |-> (acc_ff < mod_ff))
      else $error("result not reduced");

endmodule

// ===== src/rsame_cell.sv =====
// ----------------------------------------------------------------------------
// rsame_cell: one step of the interleaved modular multiplier
// Doubles the partial remainder, adds the multiplicand when the top
// multiplier bit is set, reduces back below the modulus and registers it.
// ----------------------------------------------------------------------------
module rsame_cell (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [rsame_pkg::DATA_W-1:0]   modulus,
   input  rsame_pkg::op_type              op_in,
   output rsame_pkg::op_type              op_out
);

   localparam int TW = rsame_pkg::DATA_W + 2;

   rsame_pkg::op_type stage_ff, stage_in;
   logic [TW-1:0]     sum;
   logic [TW-1:0]     mod1;
   logic [TW-1:0]     mod2;
   logic [TW-1:0]     red;

   // shift, add and reduce (sum stays below three times the modulus)
   always_comb begin
      mod1 = {2'b00, modulus};
      mod2 = {1'b0, modulus, 1'b0};
      sum  = {1'b0, op_in.r, 1'b0}
           + {2'b00, (op_in.a[rsame_pkg::DATA_W-1] ? op_in.b
                                                   : {rsame_pkg::DATA_W{1'b0}})};
      if (sum >= mod2) begin
         red = sum - mod2;
      end else if (sum >= mod1) begin
         red = sum - mod1;
      end else begin
         red = sum;
      end
      stage_in       = op_in;
      stage_in.r     = red[rsame_pkg::DATA_W-1:0];
      stage_in.a     = {op_in.a[rsame_pkg::DATA_W-2:0], 1'b0};
   end

   // stage register, only the valid bit is cleared
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else begin
         stage_ff.valid <= stage_in.valid;
      end
      stage_ff.tag <= stage_in.tag;
      stage_ff.r   <= stage_in.r;
      stage_ff.a   <= stage_in.a;
      stage_ff.b   <= stage_in.b;
   end

   assign op_out = stage_ff;

endmodule

// ===== src/rsame_chain.sv =====
// ----------------------------------------------------------------------------
// rsame_chain: modular multiplier as a row of cells
// One cell per multiplier bit; a product enters at one end and leaves the
// other end fully reduced, registered once in every cell. Several products
// may be in flight at once.
// ----------------------------------------------------------------------------
module rsame_chain #(
   parameter int CELLS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [rsame_pkg::DATA_W-1:0]   modulus,
   input  rsame_pkg::op_type              op_in,
   output rsame_pkg::op_type              op_out
);

   rsame_pkg::op_type link [0:CELLS];

   assign link[0] = op_in;

   // row of identical cells, each feeding its neighbour
   for (genvar i = 0; i < CELLS; i++) begin : g_cell
      rsame_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .modulus (modulus),
         .op_in   (link[i]),
         .op_out  (link[i+1])
      );
   end

   assign op_out = link[CELLS];

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: modular exponentiation block
// Drives words through the request channel under several key settings and
// random idling on both sides, predicts each result by square-and-multiply
// and checks every response word in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

   // one expected response word
   typedef struct {
      logic [15:0] result;
      logic        last_out;
   } modexp_word_type;

   // in-order store of predicted words and the key registers they use
   class modexp_sb_type;
      logic [15:0] pub_exp;
      logic [15:0] priv_exp;
      logic [15:0] modulus;
      modexp_word_type pending[$];
      int errors;
      int checked;

      function new();
         pub_exp  = 16'd1;
         priv_exp = 16'd1;
         modulus  = 16'd1;
         errors   = 0;
         checked  = 0;
      endfunction

      function void set_reg(logic [1:0] idx, logic [15:0] val);
         if (idx == rsame_pkg::CSR_PUBLIC_EXP) pub_exp = val;
         else if (idx == rsame_pkg::CSR_PRIVATE_EXP) priv_exp = val;
         else if (idx == rsame_pkg::CSR_MODULUS) modulus = val;
      endfunction

      // right-to-left square-and-multiply at double width
      function logic [15:0] power_mod(logic [15:0] base_in, logic [15:0] expo_in);
         logic [31:0] acc;
         logic [31:0] base_w;
         logic [15:0] e;
         if (modulus <= 16'd1) return 16'd0;
         base_w = base_in % modulus;
         acc = 32'd1;
         e = expo_in;
         while (e != 16'd0) begin
            if (e[0]) acc = (acc * base_w) % modulus;
            base_w = (base_w * base_w) % modulus;
            e = e >> 1;
         end
         return acc[15:0];
      endfunction

      function void note_word(logic action, logic [15:0] msg, logic last);
         modexp_word_type w;
         w.result = power_mod(msg, action ? priv_exp : pub_exp);
         w.last_out = last;
         pending = {pending, w};
      endfunction

      function void check_word(logic [15:0] result, logic last);
         modexp_word_type w;
         if (pending.size() == 0) begin
            report("response word with nothing expected", 0, result);
            return;
         end
         w = pending.pop_front();
         checked++;
         if (result !== w.result) report("result", w.result, result);
         if (last !== w.last_out) report("last_out", w.last_out, last);
      endfunction

      function void report(string what, logic [15:0] exp_v, logic [15:0] got_v);
         errors++;
         $display("mismatch on %s: expected %0d got %0d at %0t", what, exp_v, got_v, $time);
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_action;
   logic [15:0] req_message;
   logic        req_last_in;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [15:0] rsp_result;
   logic        rsp_last_out;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [15:0] csr_data;

   modexp_sb_type sb;
   int  send_idle_pct;
   int  recv_idle_pct;
   int  quiet_cycles;
   int  words_sent;

   localparam int WORD_CYCLES = 17 * 19 + 1;
   localparam int QUIET_LIMIT = 4 * WORD_CYCLES + 2000;
   // index with no register behind it
   localparam logic [1:0] CSR_UNUSED = 2'd3;

   rsa_modular_exponentiation_top #(.KEY_BITS(16)) i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_action(req_action),
      .req_message(req_message), .req_last_in(req_last_in),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_result(rsp_result),
      .rsp_last_out(rsp_last_out),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver stall and response checking
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) sb.check_word(rsp_result, rsp_last_out);
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // watchdog on cycles with no accepted word
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > QUIET_LIMIT) begin
         $display("watchdog: no progress for %0d cycles", quiet_cycles);
         $display("testbench: errors");
         $finish;
      end
   end

   // csr_valid stays high after the write; the caller drops it
   task automatic write_reg(logic [1:0] idx, logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.set_reg(idx, val);
   endtask

   task automatic set_key(logic [15:0] e_pub, logic [15:0] e_priv, logic [15:0] n);
      write_reg(rsame_pkg::CSR_PUBLIC_EXP, e_pub);
      write_reg(rsame_pkg::CSR_PRIVATE_EXP, e_priv);
      write_reg(rsame_pkg::CSR_MODULUS, n);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // wait for every predicted word to come back
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // req_valid stays high after acceptance; the next word reuses it or drain drops it
   task automatic send_word(logic action, logic [15:0] msg, logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_action  <= action;
      req_message <= msg;
      req_last_in <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_word(action, msg, last);
      words_sent++;
   endtask

   task automatic random_words(int count);
      logic [15:0] msg;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(3))
            0: msg = sb.modulus - 16'd1;
            1: msg = 16'($urandom_range(65535));
            default: msg = (sb.modulus > 0) ? 16'($urandom_range(sb.modulus - 1)) : 16'd0;
         endcase
         send_word(1'($urandom_range(1)), msg, ($urandom_range(7) == 0));
      end
   endtask

   initial begin
      logic [15:0] n;
      sb = new();
      reset = 1'b1;
      req_valid = 1'b0; req_action = 1'b0; req_message = '0; req_last_in = 1'b0;
      csr_valid = 1'b0; csr_index = '0; csr_data = '0;
      send_idle_pct = 0; recv_idle_pct = 0;
      words_sent = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset key: modulus one gives zero
      send_word(1'b0, 16'hFFFF, 1'b1);
      send_word(1'b1, 16'h1234, 1'b0);
      drain();

      // textbook key n = 3233, e = 17, d = 2753
      set_key(16'd17, 16'd2753, 16'd3233);
      send_word(1'b0, 16'd65, 1'b0);
      send_word(1'b1, 16'd2790, 1'b1);
      send_word(1'b0, 16'd0, 1'b0);
      send_word(1'b0, 16'd3233, 1'b0);
      send_word(1'b1, 16'hFFFF, 1'b1);
      send_word(1'b0, 16'd3232, 1'b0);
      drain();

      // exponent zero, and a write to the unused index
      set_key(16'd0, 16'hFFFF, 16'hFFFF);
      write_reg(CSR_UNUSED, 16'h5555);
      csr_valid <= 1'b0;
      send_word(1'b0, 16'd7, 1'b0);
      send_word(1'b1, 16'hFFFF, 1'b1);
      send_word(1'b1, 16'hFFFE, 1'b0);
      send_word(1'b1, 16'h8000, 1'b0);
      drain();

      // modulus zero and modulus two
      set_key(16'hFFFF, 16'd1, 16'd0);
      send_word(1'b0, 16'd5, 1'b1);
      drain();
      set_key(16'hFFFF, 16'd1, 16'd2);
      send_word(1'b0, 16'd5, 1'b0);
      send_word(1'b1, 16'hAAAA, 1'b1);
      send_word(1'b1, 16'h5555, 1'b0);
      drain();

      // random phases with changing keys and idling
      for (int ph = 0; ph < 12; ph++) begin
         case (ph % 3)
            0: begin send_idle_pct = 28; recv_idle_pct = 69; end
            1: begin send_idle_pct = 69; recv_idle_pct = 28; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         case (ph % 4)
            0: n = 16'($urandom_range(65535, 2));
            1: n = 16'($urandom_range(255, 2));
            2: n = 16'hFFFF;
            default: n = 16'($urandom_range(65535, 32768));
         endcase
         set_key(16'($urandom_range(65535)), 16'($urandom_range(65535)), n);
         random_words(52);
         drain();
      end
      send_idle_pct = 0; recv_idle_pct = 0;
      repeat (WORD_CYCLES) @(posedge clock);

      $display("covered %0d words over 17 key settings, checked %0d responses",
               words_sent, sb.checked);
      $display("exponent zero, modulus zero and one, unreduced messages all exercised");
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("testbench: clean");
      end else begin
         $display("%0d words left over, %0d mismatches", sb.pending.size(), sb.errors);
         $display("testbench: errors");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
src/rsame_pkg.sv
src/rsame_cell.sv
src/rsame_chain.sv
src/rsa_modular_exponentiation_top.sv
dv/testbench.sv
